FILE: rtl/core/edist_pkg.sv
package edist_pkg;

    // cost width and saturation point of every table entry
    localparam int unsigned COST_W   = 12;
    localparam logic [COST_W-1:0] COST_MAX = 12'd4095;

    // default length bounds
    localparam int unsigned MAX_FIRST_LEN_DEF  = 64;
    localparam int unsigned MAX_SECOND_LEN_DEF = 4095;

    // opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_STEP   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // data handed from one cell to the next each cycle
    typedef struct packed {
        logic              step_v;   // a second-string byte wavefront
        logic [7:0]        ch;       // second-string byte
        logic [COST_W-1:0] above;    // updated cost of the left neighbor
        logic [COST_W-1:0] diag;     // cost of the left neighbor before the update
        logic              tok_v;    // finish token
        logic [COST_W-1:0] tok_val;  // cost of the last active cell seen so far
    } link_t;

endpackage

FILE: rtl/core/edist_cell.sv
module edist_cell #(
    parameter int unsigned Index = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [7:0]             load_char,
    input  edist_pkg::link_t       link_in,
    output edist_pkg::link_t       link_out
);
    import edist_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic [7:0]        char_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    link_t             link_reg;
    link_t             link_next;

    logic [COST_W:0]   del_cost;
    logic [COST_W:0]   ins_cost;
    logic [COST_W:0]   sub_cost;
    logic [COST_W:0]   min_cost;
    logic [COST_W-1:0] upd_cost;

    // three-way minimum over the neighboring costs
    always_comb
    begin
        del_cost = {1'b0, cost_reg} + (COST_W+1)'(1);
        ins_cost = {1'b0, link_in.above} + (COST_W+1)'(1);
        sub_cost = {1'b0, link_in.diag} + (COST_W+1)'(link_in.ch != char_reg);
        min_cost = del_cost;
        if (ins_cost < min_cost)
        begin
            min_cost = ins_cost;
        end
        if (sub_cost < min_cost)
        begin
            min_cost = sub_cost;
        end
        if (min_cost > {1'b0, COST_MAX})
        begin
            upd_cost = COST_MAX;
        end
        else
        begin
            upd_cost = min_cost[COST_W-1:0];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        cost_next   = cost_reg;
        if (load)
        begin
            active_next = 1'b1;
            cost_next   = COST_W'(Index);
        end
        else if (link_in.tok_v)
        begin
            // finish token clears the cell as it passes
            active_next = 1'b0;
        end
        else if (link_in.step_v && active_reg)
        begin
            cost_next = upd_cost;
        end

        link_next.step_v  = link_in.step_v;
        link_next.ch      = link_in.ch;
        link_next.above   = cost_next;
        link_next.diag    = cost_reg;
        link_next.tok_v   = link_in.tok_v;
        link_next.tok_val = active_reg ? cost_reg : link_in.tok_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            link_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            link_reg   <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        if (load)
        begin
            char_reg <= load_char;
        end
    end

    assign link_out = link_reg;

endmodule

FILE: rtl/core/edit_distance_engine_unit.sv
// edit_distance_engine_unit: Levenshtein distance between two byte strings
//
// item channel (item_valid / item_stall, opcode + char_value):
//   append  stores one first-string byte in the next cell of the chain
//   step    sends one second-string byte down the chain as a wavefront
//   finish  sends a token down the chain that picks up the distance and
//           clears every cell behind it
// result channel (result_valid / result_stall, distance + overflow): one
//   word per finish
// appends and steps are taken back to back; steps stream one byte per cycle
//   while no finish token is in flight, each cell updating its cost in the
//   cycle after its left neighbor
// finish: the token crosses every cell and the result word shows once it
//   leaves the last cell; item_stall stays high meanwhile, so no word is
//   taken while the token is in the chain
// a finish word is held off while an earlier result word still waits;
//   appends and steps keep flowing while the receiver stalls
// reset empties both strings, clears the overflow flag and the result
//   valid flag; no sweep of the cells is needed
module edit_distance_engine_unit #(
    parameter int unsigned MAX_FIRST_LEN  = edist_pkg::MAX_FIRST_LEN_DEF,
    parameter int unsigned MAX_SECOND_LEN = edist_pkg::MAX_SECOND_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    opcode,
    input  logic [7:0]                    char_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [edist_pkg::COST_W-1:0]  distance,
    output logic                          overflow
);
    import edist_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_FIRST_LEN + 1);
    localparam int unsigned CNT_W = $clog2(MAX_SECOND_LEN + 1);

    // control state
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic              busy_reg;
    logic              busy_next;
    logic              ovf_hold_reg;
    logic              ovf_hold_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [COST_W-1:0] res_dist_reg;

    logic              accept;
    logic              do_append;
    logic              do_step;
    logic              do_finish;
    logic [COST_W-1:0] cost0_old;
    logic [COST_W-1:0] cost0_new;

    link_t             link0_reg;
    link_t             link0_next;
    link_t             chain [0:MAX_FIRST_LEN];
    logic [MAX_FIRST_LEN-1:0] cell_load;

    // saturated cost of the top row entry, old and after one more step
    always_comb
    begin
        if (32'(count_reg) > 32'(COST_MAX))
        begin
            cost0_old = COST_MAX;
        end
        else
        begin
            cost0_old = COST_W'(count_reg);
        end
        if (32'(count_reg) + 32'd1 > 32'(COST_MAX))
        begin
            cost0_new = COST_MAX;
        end
        else
        begin
            cost0_new = COST_W'(32'(count_reg) + 32'd1);
        end
    end

    assign item_stall = busy_reg || (opcode == OP_FINISH && res_valid_reg);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        do_append = 1'b0;
        do_step   = 1'b0;
        do_finish = 1'b0;
        if (accept)
        begin
            unique case (opcode)
                OP_APPEND: do_append = 1'b1;
                OP_STEP:   do_step   = 1'b1;
                OP_FINISH: do_finish = 1'b1;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        busy_next      = busy_reg;
        ovf_hold_next  = ovf_hold_reg;
        res_valid_next = res_valid_reg;

        link0_next.step_v  = 1'b0;
        link0_next.ch      = char_value;
        link0_next.above   = cost0_new;
        link0_next.diag    = cost0_old;
        link0_next.tok_v   = 1'b0;
        link0_next.tok_val = cost0_old;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (do_append)
        begin
            // appends close once the second string has started or the store is full
            if (count_reg != '0 || len_reg >= LEN_W'(MAX_FIRST_LEN))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end

        if (do_step)
        begin
            if (count_reg >= CNT_W'(MAX_SECOND_LEN))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next        = count_reg + CNT_W'(1);
                link0_next.step_v = 1'b1;
            end
        end

        if (do_finish)
        begin
            link0_next.tok_v = 1'b1;
            ovf_hold_next    = dropped_reg;
            busy_next        = 1'b1;
            len_next         = '0;
            count_next       = '0;
            dropped_next     = 1'b0;
        end

        // token leaves the last cell carrying the distance
        if (chain[MAX_FIRST_LEN].tok_v)
        begin
            busy_next      = 1'b0;
            res_valid_next = 1'b1;
        end
    end

    // one-hot load strobe for the cell that takes the next appended byte
    always_comb
    begin
        for (int unsigned y = 0; y < MAX_FIRST_LEN; y++)
        begin
            cell_load[y] = do_append && count_reg == '0 && len_reg == LEN_W'(y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            ovf_hold_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            link0_reg     <= '0;
        end
        else
        begin
            len_reg       <= len_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            busy_reg      <= busy_next;
            ovf_hold_reg  <= ovf_hold_next;
            res_valid_reg <= res_valid_next;
            link0_reg     <= link0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[MAX_FIRST_LEN].tok_v)
        begin
            res_dist_reg <= chain[MAX_FIRST_LEN].tok_val;
        end
    end

    assign chain[0] = link0_reg;

    // cell y holds first-string byte y-1 and cost entry y
    for (genvar y = 1; y <= MAX_FIRST_LEN; y++)
    begin : g_cell
        edist_cell #(
            .Index (y)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (cell_load[y-1]),
            .load_char (char_value),
            .link_in   (chain[y-1]),
            .link_out  (chain[y])
        );
    end

    assign result_valid = res_valid_reg;
    assign distance     = res_dist_reg;
    assign overflow     = ovf_hold_reg;

endmodule

FILE: dv/edit_distance_engine_unit_tb.sv
`timescale 1ns / 1ps

module edit_distance_engine_unit_tb;

    import edist_pkg::*;

    // length bounds of the instance under test
    localparam int unsigned LEN_A = MAX_FIRST_LEN_DEF;
    localparam int unsigned LEN_B = MAX_SECOND_LEN_DEF;

    // the one opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one word on the item channel
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } item_word_t;

    // one word on the result channel
    typedef struct packed {
        logic [COST_W-1:0] dist_val;
        logic              ovf;
    } score_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [1:0]        opcode = OP_APPEND;
    logic [7:0]        char_value = 8'h00;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [COST_W-1:0] distance;
    logic              overflow;

    edit_distance_engine_unit #(
        .MAX_FIRST_LEN  (LEN_A),
        .MAX_SECOND_LEN (LEN_B)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .char_value   (char_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .overflow     (overflow)
    );

    // words waiting to be sent, and distances waiting to come back
    item_word_t  pending_words[$];
    score_t      due_scores[$];
    item_word_t  next_word;

    // idle rates in percent, changed between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // set at the rising edge when the item word was taken
    bit          item_took = 1'b0;

    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned scores_checked = 0;
    int unsigned drops_seen = 0;
    int unsigned errors = 0;

    // shadow of the block's state: stored first string, cost column,
    // first-string length, second-string count and the overflow flag
    logic [7:0]  str_a[LEN_A];
    int unsigned col[LEN_A + 1];
    int unsigned len_a;
    int unsigned steps_b;
    bit          dropped;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic int unsigned clip_cost(input int unsigned v);
        return (v > COST_MAX) ? COST_MAX : v;
    endfunction

    // back to the state after reset: empty strings, column entry y holds y
    function automatic void clear_tables();
        for (int y = 0; y <= LEN_A; y++)
        begin
            col[y] = clip_cost(y);
        end
        len_a   = 0;
        steps_b = 0;
        dropped = 1'b0;
    endfunction

    // one second-string byte moves the whole column down one row
    function automatic void advance_column(input logic [7:0] ch);
        int unsigned diag;
        int unsigned old;
        int unsigned m;
        if (steps_b >= LEN_B)
        begin
            dropped = 1'b1;
            drops_seen++;
            return;
        end
        steps_b++;
        diag   = col[0];
        col[0] = clip_cost(steps_b);
        for (int y = 1; y <= len_a; y++)
        begin
            old = col[y];
            m   = old + 1;
            if (col[y-1] + 1 < m)
            begin
                m = col[y-1] + 1;
            end
            if (diag + ((str_a[y-1] == ch) ? 0 : 1) < m)
            begin
                m = diag + ((str_a[y-1] == ch) ? 0 : 1);
            end
            col[y] = clip_cost(m);
            diag   = old;
        end
    endfunction

    // update the shadow state for one taken word; finish queues a score
    function automatic void track_word(input item_word_t w);
        score_t s;
        case (w.op)
            OP_APPEND:
            begin
                // dropped once stepping has begun or the store is full
                if (steps_b != 0 || len_a >= LEN_A)
                begin
                    dropped = 1'b1;
                    drops_seen++;
                end
                else
                begin
                    str_a[len_a] = w.ch;
                    len_a++;
                    col[len_a] = clip_cost(len_a);
                end
            end
            OP_STEP:
            begin
                advance_column(w.ch);
            end
            OP_FINISH:
            begin
                s.dist_val = COST_W'(col[len_a]);
                s.ovf      = dropped;
                due_scores.push_back(s);
                clear_tables();
            end
            default:
            begin
                // unused opcode, no effect at all
            end
        endcase
    endfunction

    // monitor: everything sampled at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_took = 1'b0;
        end
        else
        begin
            // result side first: a finish taken now cannot answer this edge
            if (result_valid && !result_stall)
            begin
                if (due_scores.size() == 0)
                begin
                    report_mismatch($sformatf("result word with none due: dist %0d ovf %0b",
                                              distance, overflow));
                end
                else
                begin
                    if (distance !== due_scores[0].dist_val)
                    begin
                        report_mismatch($sformatf("distance %0d, due %0d",
                                                  distance, due_scores[0].dist_val));
                    end
                    if (overflow !== due_scores[0].ovf)
                    begin
                        report_mismatch($sformatf("overflow %0b, due %0b",
                                                  overflow, due_scores[0].ovf));
                    end
                    void'(due_scores.pop_front());
                    scores_checked++;
                end
            end
            item_took = item_valid && !item_stall;
            if (item_took)
            begin
                track_word('{op: opcode, ch: char_value});
                words_taken++;
            end
        end
    end

    // driver: new word or idle at the falling edge, only once the last
    // word was taken; a stalled word is held as it is
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_took)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    item_valid <= 1'b1;
                    opcode     <= next_word.op;
                    char_value <= next_word.ch;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_word(input logic [1:0] op, input logic [7:0] ch);
        pending_words.push_back('{op: op, ch: ch});
        words_queued++;
    endtask

    // mostly near one base byte so matches are common, sometimes any byte
    function automatic logic [7:0] pick_char(input logic [7:0] base);
        if ($urandom_range(99) < 20)
        begin
            return 8'($urandom_range(255));
        end
        return base ^ 8'($urandom_range(3));
    endfunction

    // one pair of strings closed by a finish, with a little noise mixed in, or at times a shapeless run
    task automatic push_sequence();
        int unsigned n_a;
        int unsigned n_b;
        int unsigned r;
        logic [7:0]  base;
        r    = $urandom_range(99);
        base = 8'($urandom_range(255));
        if (r < 5)
        begin
            // shapeless: any opcode, any byte
            repeat ($urandom_range(12))
            begin
                push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
            push_word(OP_FINISH, 8'($urandom_range(255)));
            return;
        end
        r = $urandom_range(99);
        if (r < 85)
        begin
            n_a = $urandom_range(10);
        end
        else if (r < 95)
        begin
            n_a = $urandom_range(64, 11);
        end
        else
        begin
            // fill the first string and sometimes run past its end
            n_a = $urandom_range(LEN_A + 3, LEN_A);
        end
        n_b = ($urandom_range(99) < 85) ? $urandom_range(10) : $urandom_range(40, 11);
        repeat (n_a)
        begin
            push_word(OP_APPEND, pick_char(base));
        end
        repeat (n_b)
        begin
            push_word(OP_STEP, pick_char(base));
            if ($urandom_range(99) < 3)
            begin
                push_word(OP_UNUSED, 8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 3)
            begin
                // late append, must be dropped
                push_word(OP_APPEND, pick_char(base));
            end
        end
        push_word(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // wait until every queued word is taken and every score is back
    task automatic drain();
        while (words_taken != words_queued || due_scores.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned start;
        start = words_queued;
        while (words_queued - start < budget)
        begin
            push_sequence();
        end
        drain();
    endtask

    initial
    begin
        clear_tables();
        repeat (8)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // phase one: sender rarely idle, receiver mostly stalled
        send_idle_pct = 14;
        recv_idle_pct = 81;

        // directed: finish on empty strings, then the unused opcode
        push_word(OP_FINISH, 8'h00);
        push_word(OP_UNUSED, 8'hff);
        // byte extremes, a late append that is dropped, unused opcode mid-way
        push_word(OP_APPEND, 8'h00);
        push_word(OP_APPEND, 8'hff);
        push_word(OP_STEP, 8'hff);
        push_word(OP_APPEND, 8'haa);
        push_word(OP_UNUSED, 8'h80);
        push_word(OP_STEP, 8'h00);
        push_word(OP_STEP, 8'h55);
        push_word(OP_FINISH, 8'hff);
        // second string only
        push_word(OP_STEP, 8'h01);
        push_word(OP_STEP, 8'h02);
        push_word(OP_FINISH, 8'h7f);
        // first string only, then two finishes back to back
        push_word(OP_APPEND, 8'h10);
        push_word(OP_APPEND, 8'h20);
        push_word(OP_APPEND, 8'h30);
        push_word(OP_FINISH, 8'h00);
        push_word(OP_FINISH, 8'h00);
        // equal strings give zero
        push_word(OP_APPEND, 8'h5a);
        push_word(OP_APPEND, 8'ha5);
        push_word(OP_STEP, 8'h5a);
        push_word(OP_STEP, 8'ha5);
        push_word(OP_FINISH, 8'h00);
        drain();
        run_random(230);

        // phase two: sender mostly idle, receiver rarely stalled
        send_idle_pct = 81;
        recv_idle_pct = 14;
        run_random(230);

        // phase three: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(230);

        // first string full plus one, then a run of second-string bytes
        repeat (LEN_A + 1)
        begin
            push_word(OP_APPEND, 8'($urandom_range(255)));
        end
        repeat (20)
        begin
            push_word(OP_STEP, 8'($urandom_range(255)));
        end
        push_word(OP_FINISH, 8'h00);
        drain();

        // room for a stray result word to show up
        repeat (LEN_A + 16)
        begin
            @(posedge clk);
        end

        $display("covered %0d item words and %0d distance words, %0d dropped bytes",
                 words_taken, scores_checked, drops_seen);
        $display("a full first string, late appends and all three idle phases were exercised");
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hard stop if the handshake hangs
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: edit_distance_engine_unit.f
rtl/core/edist_pkg.sv
rtl/core/edist_cell.sv
rtl/core/edit_distance_engine_unit.sv
dv/edit_distance_engine_unit_tb.sv
